### sv/env_sensor_compensation_macros.svh
// Assertion macros for the environmental sensor compensation block
`ifndef ENV_SENSOR_COMPENSATION_MACROS_SVH
`define ENV_SENSOR_COMPENSATION_MACROS_SVH

// same-cycle implication
`define ESC_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ESC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/esc_pkg.sv
// Shared types, register indexes and constants of the sensor compensation block
package esc_pkg;

  typedef struct packed {
    logic [19:0] raw_pressure;
    logic [19:0] raw_temperature;
    logic [15:0] raw_humidity;
  } esc_in_t;

  typedef struct packed {
    logic signed [26:0] temperature_centi;
    logic [31:0]        pressure_q24_8;
    logic [16:0]        humidity_q22_10;
    logic               pressure_valid;
  } esc_out_t;

  localparam logic [2:0] REG_TEMP_CAL       = 3'd0;
  localparam logic [2:0] REG_PRESS_CAL_LOW  = 3'd1;
  localparam logic [2:0] REG_PRESS_CAL_HIGH = 3'd2;
  localparam logic [2:0] REG_PRESS_CAL_NINE = 3'd3;
  localparam logic [2:0] REG_HUM_CAL        = 3'd4;

  localparam int TEMP_LAT   = 4;
  localparam int PFRONT_LAT = 5;
  localparam int DIV_STEPS  = 64;
  localparam int DIV_LAT    = DIV_STEPS + 2;
  localparam int PBACK_LAT  = 5;
  localparam int HUM_LAT    = 8;
  localparam int PIPE_LAT   = TEMP_LAT + PFRONT_LAT + DIV_LAT + PBACK_LAT;

  localparam logic signed [22:0] P_TFINE_OFS  = 23'sd128000;
  localparam logic [20:0]        P_RAW_BASE   = 21'd1048576;
  localparam logic [63:0]        P_SCALE      = 64'd3125;
  localparam logic signed [63:0] P_V1_BIAS    = 64'sd140737488355328;
  localparam logic signed [31:0] H_TFINE_OFS  = 32'sd76800;
  localparam logic signed [31:0] H_LEFT_RND   = 32'sd16384;
  localparam logic signed [31:0] H_S_BIAS     = 32'sd32768;
  localparam logic signed [31:0] H_R_BIAS     = 32'sd2097152;
  localparam logic signed [31:0] H_R_RND      = 32'sd8192;
  localparam logic signed [31:0] H_LIMIT      = 32'sd419430400;
  localparam logic signed [25:0] T_RND        = 26'sd128;

endpackage

### sv/env_sensor_compensation.sv
// Top level of the environmental sensor compensation block
// Fully pipelined integer compensation of one temperature, pressure and humidity
// sample per transaction: a new transaction is taken every clock cycle unless
// a stalled result holds the pipeline, and results appear in order. The latency is
// set by the pressure path: a 4-stage temperature front end, 5 pressure stages,
// a 66-stage divider whose inner stages each resolve one quotient bit, and
// 5 stages of pressure correction and saturation. A stalled result freezes the
// whole pipeline; input is taken whenever the output register is empty or being
// drained. Calibration registers are written through the plain write port and
// must be stable while transactions are in flight.
module env_sensor_compensation import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  esc_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output esc_out_t    out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [63:0] cfg_wdata_i
);

  logic [47:0] temp_cal_q;
  logic [63:0] press_cal_low_q, press_cal_high_q, hum_cal_q;
  logic [15:0] press_cal_nine_q;
  logic [PIPE_LAT-1:0] vld_q;
  logic        en;

  logic signed [21:0] t_fine;
  logic [19:0]        raw_p_d;
  logic [15:0]        raw_h_d;
  logic signed [25:0] tf_ext, t5;
  logic signed [26:0] temp_c, temp_out;
  logic [63:0]        dividend, quotient;
  logic signed [30:0] divisor;
  logic               div_ok, ok_out;
  logic [31:0]        press;
  logic [16:0]        hum, hum_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_cal_q       <= '0;
      press_cal_low_q  <= '0;
      press_cal_high_q <= '0;
      press_cal_nine_q <= '0;
      hum_cal_q        <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TEMP_CAL:       temp_cal_q       <= cfg_wdata_i[47:0];
        REG_PRESS_CAL_LOW:  press_cal_low_q  <= cfg_wdata_i;
        REG_PRESS_CAL_HIGH: press_cal_high_q <= cfg_wdata_i;
        REG_PRESS_CAL_NINE: press_cal_nine_q <= cfg_wdata_i[15:0];
        REG_HUM_CAL:        hum_cal_q        <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign en         = !vld_q[PIPE_LAT-1] || !out_stall_i;
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_LAT-2:0], in_valid_i};
    end
  end

  esc_temp u_temp (
    .clk_i             (clk_i),
    .en_i              (en),
    .raw_temperature_i (in_data_i.raw_temperature),
    .temp_cal_i        (temp_cal_q),
    .t_fine_o          (t_fine)
  );

  esc_delay #(.W(20), .N(TEMP_LAT)) u_dly_rawp (
    .clk_i (clk_i), .en_i (en), .d_i (in_data_i.raw_pressure), .q_o (raw_p_d)
  );

  esc_delay #(.W(16), .N(TEMP_LAT)) u_dly_rawh (
    .clk_i (clk_i), .en_i (en), .d_i (in_data_i.raw_humidity), .q_o (raw_h_d)
  );

  assign tf_ext = 26'(t_fine);
  assign t5     = (tf_ext <<< 2) + tf_ext + T_RND;
  assign temp_c = 27'($signed(t5[25:8]));

  esc_delay #(.W(27), .N(PIPE_LAT - TEMP_LAT)) u_dly_temp (
    .clk_i (clk_i), .en_i (en), .d_i (temp_c), .q_o (temp_out)
  );

  esc_pfront u_pfront (
    .clk_i           (clk_i),
    .en_i            (en),
    .t_fine_i        (t_fine),
    .raw_pressure_i  (raw_p_d),
    .press_cal_low_i (press_cal_low_q),
    .press_cal_p56_i (press_cal_high_q[31:0]),
    .dividend_o      (dividend),
    .divisor_o       (divisor),
    .div_ok_o        (div_ok)
  );

  esc_div u_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quotient_o (quotient)
  );

  esc_delay #(.W(1), .N(DIV_LAT + PBACK_LAT)) u_dly_ok (
    .clk_i (clk_i), .en_i (en), .d_i (div_ok), .q_o (ok_out)
  );

  esc_pback u_pback (
    .clk_i            (clk_i),
    .en_i             (en),
    .p_i              (quotient),
    .press_cal_p78_i  (press_cal_high_q[63:32]),
    .press_cal_nine_i (press_cal_nine_q),
    .press_o          (press)
  );

  esc_hum u_hum (
    .clk_i          (clk_i),
    .en_i           (en),
    .t_fine_i       (t_fine),
    .raw_humidity_i (raw_h_d),
    .hum_cal_i      (hum_cal_q),
    .humidity_o     (hum)
  );

  esc_delay #(.W(17), .N(PIPE_LAT - TEMP_LAT - HUM_LAT)) u_dly_hum (
    .clk_i (clk_i), .en_i (en), .d_i (hum), .q_o (hum_out)
  );

  assign out_valid_o                  = vld_q[PIPE_LAT-1];
  assign out_data_o.temperature_centi = temp_out;
  assign out_data_o.pressure_q24_8    = ok_out ? press : '0;
  assign out_data_o.humidity_q22_10   = hum_out;
  assign out_data_o.pressure_valid    = ok_out;

endmodule

### sv/esc_delay.sv
// Enabled shift line that delays a payload word by a fixed number of stages
module esc_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] pipe_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pipe_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        pipe_q[i] <= pipe_q[i-1];
      end
    end
  end

  assign q_o = pipe_q[N-1];

endmodule

### sv/esc_mul64lo.sv
// Two-stage multiplier giving the low 64 bits of a 64 by 64 product
module esc_mul64lo (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  output logic [63:0] p_o
);

  logic [63:0] ll_d, ll_q;
  logic [31:0] hl_d, hl_q, lh_d, lh_q;
  logic [63:0] p_q;

  assign ll_d = {32'b0, a_i[31:0]} * {32'b0, b_i[31:0]};
  assign hl_d = a_i[63:32] * b_i[31:0];
  assign lh_d = a_i[31:0] * b_i[63:32];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ll_q <= ll_d;
      hl_q <= hl_d;
      lh_q <= lh_d;
      p_q  <= ll_q + {hl_q + lh_q, 32'b0};
    end
  end

  assign p_o = p_q;

endmodule

### sv/esc_temp.sv
// Temperature pipeline producing the fine temperature value
module esc_temp import esc_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [19:0]        raw_temperature_i,
  input  logic [47:0]        temp_cal_i,
  output logic signed [21:0] t_fine_o
);

  logic signed [15:0] t2, t3;
  logic signed [17:0] diff_a;
  logic signed [33:0] prod_a;
  logic signed [16:0] d_d;
  logic signed [31:0] a_prod_q;
  logic signed [16:0] d_q;
  logic signed [33:0] prod_dd;
  logic signed [31:0] dd_q;
  logic signed [20:0] a_q, a2_q;
  logic signed [19:0] dd_s;
  logic signed [35:0] prod_b;
  logic signed [31:0] b_prod_q;
  logic signed [17:0] b_s;
  logic signed [21:0] t_fine_d, t_fine_q;

  assign t2 = temp_cal_i[31:16];
  assign t3 = temp_cal_i[47:32];

  assign diff_a = $signed({1'b0, raw_temperature_i[19:3]})
                - $signed({1'b0, temp_cal_i[15:0], 1'b0});
  assign prod_a = diff_a * t2;
  assign d_d    = $signed({1'b0, raw_temperature_i[19:4]}) - $signed({1'b0, temp_cal_i[15:0]});

  assign prod_dd = d_q * d_q;
  assign dd_s    = dd_q[31:12];
  assign prod_b  = dd_s * t3;
  assign b_s     = b_prod_q[31:14];
  assign t_fine_d = a2_q + b_s;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_prod_q <= prod_a[31:0];
      d_q      <= d_d;
      dd_q     <= prod_dd[31:0];
      a_q      <= a_prod_q[31:11];
      b_prod_q <= prod_b[31:0];
      a2_q     <= a_q;
      t_fine_q <= t_fine_d;
    end
  end

  assign t_fine_o = t_fine_q;

endmodule

### sv/esc_pfront.sv
// Pressure pipeline up to the dividend and divisor of the pressure division
module esc_pfront import esc_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [21:0] t_fine_i,
  input  logic [19:0]        raw_pressure_i,
  input  logic [63:0]        press_cal_low_i,
  input  logic [31:0]        press_cal_p56_i,
  output logic [63:0]        dividend_o,
  output logic signed [30:0] divisor_o,
  output logic               div_ok_o
);

  logic signed [15:0] p2, p3, p4, p5, p6;
  logic signed [16:0] p1s;
  logic signed [22:0] v1;
  logic signed [45:0] vv_q;
  logic signed [38:0] v1p5_q, v1p2_q, v1p5_b_q, v1p2_b_q;
  logic signed [61:0] vv6_q, vv3_q;
  logic [19:0]        raw_a_q, raw_b_q, raw_c_q;
  logic signed [63:0] v2_d, v2_q, v1b_d;
  logic signed [55:0] v1b_q;
  logic signed [72:0] prod1;
  logic signed [30:0] v1c_q, v1c_e_q;
  logic [20:0]        pdiff;
  logic [63:0]        num_d, num_q, num3125_q;

  assign p1s = $signed({1'b0, press_cal_low_i[15:0]});
  assign p2  = press_cal_low_i[31:16];
  assign p3  = press_cal_low_i[47:32];
  assign p4  = press_cal_low_i[63:48];
  assign p5  = press_cal_p56_i[15:0];
  assign p6  = press_cal_p56_i[31:16];

  assign v1 = t_fine_i - P_TFINE_OFS;

  assign v2_d  = vv6_q + (v1p5_b_q <<< 17) + (p4 <<< 35);
  assign v1b_d = (vv3_q >>> 8) + (v1p2_b_q <<< 12) + P_V1_BIAS;

  assign prod1 = v1b_q * p1s;
  assign pdiff = P_RAW_BASE - {1'b0, raw_c_q};
  assign num_d = {12'b0, pdiff, 31'b0} - v2_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      vv_q      <= v1 * v1;
      v1p5_q    <= v1 * p5;
      v1p2_q    <= v1 * p2;
      raw_a_q   <= raw_pressure_i;
      vv6_q     <= vv_q * p6;
      vv3_q     <= vv_q * p3;
      v1p5_b_q  <= v1p5_q;
      v1p2_b_q  <= v1p2_q;
      raw_b_q   <= raw_a_q;
      v2_q      <= v2_d;
      v1b_q     <= v1b_d[55:0];
      raw_c_q   <= raw_b_q;
      v1c_q     <= prod1[63:33];
      num_q     <= num_d;
      num3125_q <= num_q * P_SCALE;
      v1c_e_q   <= v1c_q;
    end
  end

  assign dividend_o = num3125_q;
  assign divisor_o  = v1c_e_q;
  assign div_ok_o   = (v1c_e_q != '0);

endmodule

### sv/esc_div.sv
// Pipelined signed divider, one quotient bit per stage, truncating toward zero
module esc_div import esc_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [63:0]        dividend_i,
  input  logic signed [30:0] divisor_i,
  output logic [63:0]        quotient_o
);

  logic [30:0] rem_q [DIV_STEPS+1];
  logic [63:0] acc_q [DIV_STEPS+1];
  logic [30:0] ub_q  [DIV_STEPS+1];
  logic        neg_q [DIV_STEPS+1];
  logic [31:0] trial [DIV_STEPS];
  logic [DIV_STEPS-1:0] ge;
  logic [63:0] ua;
  logic [30:0] ub;
  logic [63:0] quo_q;

  assign ua = dividend_i[63] ? (~dividend_i + 64'd1) : dividend_i;
  assign ub = divisor_i[30] ? (~divisor_i + 31'd1) : divisor_i;

  always_comb begin
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial[k] = {rem_q[k], acc_q[k][63]};
      ge[k]    = (trial[k] >= {1'b0, ub_q[k]});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= '0;
      acc_q[0] <= ua;
      ub_q[0]  <= ub;
      neg_q[0] <= dividend_i[63] ^ divisor_i[30];
      for (int k = 0; k < DIV_STEPS; k++) begin
        rem_q[k+1] <= ge[k] ? 31'(trial[k] - {1'b0, ub_q[k]}) : trial[k][30:0];
        acc_q[k+1] <= {acc_q[k][62:0], ge[k]};
        ub_q[k+1]  <= ub_q[k];
        neg_q[k+1] <= neg_q[k];
      end
      quo_q <= neg_q[DIV_STEPS] ? (~acc_q[DIV_STEPS] + 64'd1) : acc_q[DIV_STEPS];
    end
  end

  assign quotient_o = quo_q;

endmodule

### sv/esc_pback.sv
// Pressure pipeline after the division: correction terms, offset and saturation
module esc_pback import esc_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] p_i,
  input  logic [31:0] press_cal_p78_i,
  input  logic [15:0] press_cal_nine_i,
  output logic [31:0] press_o
);

  logic signed [15:0] p7, p8, p9;
  logic signed [63:0] ps;
  logic signed [50:0] q;
  logic signed [66:0] pq9_full;
  logic signed [79:0] w2_full;
  logic [63:0]        pq9_q, qx_q, w1p;
  logic signed [63:0] w2p_q, w2p_b_q, w2p_c_q;
  logic signed [63:0] p_q, p_b_q, p_c_q;
  logic signed [63:0] s_d, s_q, pf;
  logic [31:0]        press_d, press_q;

  assign p7 = press_cal_p78_i[15:0];
  assign p8 = press_cal_p78_i[31:16];
  assign p9 = press_cal_nine_i;
  assign ps = p_i;
  assign q  = ps[63:13];

  assign pq9_full = p9 * q;
  assign w2_full  = p8 * ps;

  esc_mul64lo u_mul (
    .clk_i (clk_i),
    .en_i  (en_i),
    .a_i   (pq9_q),
    .b_i   (qx_q),
    .p_o   (w1p)
  );

  assign s_d = p_c_q + ($signed(w1p) >>> 25) + (w2p_c_q >>> 19);
  assign pf  = (s_q >>> 8) + (p7 <<< 4);

  always_comb begin
    if (pf[63]) begin
      press_d = '0;
    end else if (pf[63:32] != '0) begin
      press_d = '1;
    end else begin
      press_d = pf[31:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pq9_q   <= pq9_full[63:0];
      qx_q    <= 64'(q);
      w2p_q   <= w2_full[63:0];
      p_q     <= ps;
      w2p_b_q <= w2p_q;
      w2p_c_q <= w2p_b_q;
      p_b_q   <= p_q;
      p_c_q   <= p_b_q;
      s_q     <= s_d;
      press_q <= press_d;
    end
  end

  assign press_o = press_q;

endmodule

### sv/esc_hum.sv
// Humidity pipeline with clamping to the valid range
module esc_hum import esc_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [21:0] t_fine_i,
  input  logic [15:0]        raw_humidity_i,
  input  logic [63:0]        hum_cal_i,
  output logic [16:0]        humidity_o
);

  logic signed [31:0] h1s, h3s;
  logic signed [15:0] h2;
  logic signed [11:0] h4, h5;
  logic signed [7:0]  h6;
  logic signed [31:0] x, la_d, la_q, rx6_q, sx3_q;
  logic signed [31:0] la_sum, s_d, s_q, rs_q, r2, r2h_q, r3_sum;
  logic signed [16:0] left_q, left_b_q, left_c_q;
  logic signed [21:0] r_q;
  logic signed [17:0] r3;
  logic signed [31:0] xx_q, xx_b_q, xx_c_q, sqp_q, sh_q, y;
  logic signed [16:0] xs;
  logic signed [24:0] sq;
  logic [16:0]        hum_d, hum_q;

  assign h1s = $signed({24'b0, hum_cal_i[7:0]});
  assign h2  = hum_cal_i[23:8];
  assign h3s = $signed({24'b0, hum_cal_i[31:24]});
  assign h4  = hum_cal_i[43:32];
  assign h5  = hum_cal_i[55:44];
  assign h6  = hum_cal_i[63:56];

  assign x    = t_fine_i - H_TFINE_OFS;
  assign la_d = $signed({2'b00, raw_humidity_i, 14'b0}) - (h4 <<< 20) - (h5 * x);

  assign la_sum = la_q + H_LEFT_RND;
  assign s_d    = (sx3_q >>> 11) + H_S_BIAS;
  assign r2     = (rs_q >>> 10) + H_R_BIAS;
  assign r3_sum = r2h_q + H_R_RND;
  assign r3     = r3_sum[31:14];
  assign xs     = xx_q[31:15];
  assign sq     = sqp_q[31:7];
  assign y      = xx_c_q - (sh_q >>> 4);

  always_comb begin
    if (y[31]) begin
      hum_d = '0;
    end else if (y > H_LIMIT) begin
      hum_d = H_LIMIT[28:12];
    end else begin
      hum_d = y[28:12];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      la_q     <= la_d;
      rx6_q    <= x * h6;
      sx3_q    <= x * h3s;
      left_q   <= la_sum[31:15];
      r_q      <= rx6_q[31:10];
      s_q      <= s_d;
      rs_q     <= r_q * s_q;
      left_b_q <= left_q;
      r2h_q    <= r2 * h2;
      left_c_q <= left_b_q;
      xx_q     <= left_c_q * r3;
      sqp_q    <= xs * xs;
      xx_b_q   <= xx_q;
      sh_q     <= sq * h1s;
      xx_c_q   <= xx_b_q;
      hum_q    <= hum_d;
    end
  end

  assign humidity_o = hum_q;

endmodule

### sv/esc_checker.sv
// Port-level checker for the sensor compensation block and its bind
`include "env_sensor_compensation_macros.svh"

module esc_checker import esc_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_stall_o,
  input logic     out_valid_o,
  input logic     out_stall_i,
  input esc_out_t out_data_o
);

  `ESC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled transaction changed")
  `ESC_ASSERT_IMP(a_take_when_empty, clk_i, rst_ni, !out_valid_o, !in_stall_o, "input stalled with empty output")
  `ESC_ASSERT_IMP(a_hum_range, clk_i, rst_ni, out_valid_o, out_data_o.humidity_q22_10 <= 17'd102400, "humidity above clamp")
  `ESC_ASSERT_IMP(a_press_gated, clk_i, rst_ni, out_valid_o && !out_data_o.pressure_valid, out_data_o.pressure_q24_8 == 32'd0, "pressure not zero when invalid")

endmodule

bind env_sensor_compensation esc_checker u_esc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
